>>> src/iqpdb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iqpdb_pkg: shared constants of the I/Q window power meter
// Field widths, log2 fraction table and dB scaling constants.
// ----------------------------------------------------------------------------
package iqpdb_pkg;

	localparam int SAMPLE_W        = 12;
	localparam int DB_W            = 12;
	localparam int USED_W          = 11;
	// |sample|^2 reaches 2^22, so one square needs 23 bits
	localparam int SQ_W            = 23;
	// Q8 log2 values and their difference fit 16 bits signed
	localparam int LOG_W           = 16;
	localparam int MUL_W           = 16;
	localparam int PROD_W          = 2 * MUL_W;
	localparam int FRAC_IDX_W      = 5;
	localparam int FRAC_W          = 8;
	localparam int DEF_MAX_WINDOW  = 1024;

	localparam logic signed [DB_W-1:0]   FLOOR_RESET = -12'sd1920;
	// round(16 * 256 * 10 * log10(2))
	localparam logic signed [MUL_W-1:0]  DB_SCALE    = 16'sd12330;
	// log2(2048^2) in Q8 log2 units
	localparam logic signed [LOG_W-1:0]  FS_LOG2_Q8  = 16'sd5632;
	localparam logic signed [PROD_W-1:0] ROUND_HALF  = 32'sd32768;

	// round(256 * log2(1 + k/32))
	localparam logic [FRAC_W-1:0] LOG_FRAC [2**FRAC_IDX_W] = '{
		8'd0,   8'd11,  8'd22,  8'd33,  8'd44,  8'd54,  8'd63,  8'd73,
		8'd82,  8'd92,  8'd100, 8'd109, 8'd118, 8'd126, 8'd134, 8'd142,
		8'd150, 8'd157, 8'd165, 8'd172, 8'd179, 8'd186, 8'd193, 8'd200,
		8'd207, 8'd213, 8'd220, 8'd226, 8'd232, 8'd238, 8'd244, 8'd250
	};

endpackage

>>> src/iq_window_power_db_meter_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// iq_window_power_db_meter_unit: windowed mean I/Q power in dBFS
// Sums I*I+Q*Q over a window and reports the mean power in 1/16 dB.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              word
//  --------  ---------  ---------------------  ---------------------------------
//  input     in         in_valid / in_stall    i_sample, q_sample, window_end
//  output    out        out_valid / out_stall  power_db, samples_used
//  config    in         cfg_wr_en              cfg_wr_data (floor_db)
//
//  A word that does not end the window passes the steps accept, square I, square Q
//  and accumulate; the two squares go through the one shared 16x16 signed multiplier.
//  A window-end word then adds a load step, leading-one shift steps in the shared
//  normalizer for the sum and then for the count, a scale multiply and an emit step.
//  Reset clears the accumulators, the sequencer and the output valid, and sets the
//  floor to -120 dB. A stalled output holds the sequencer in its emit step.
//
module iq_window_power_db_meter_unit
	import iqpdb_pkg::*;
#(
	parameter int MAX_WINDOW = DEF_MAX_WINDOW
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// configuration
	input  logic                       cfg_wr_en,
	input  logic signed [DB_W-1:0]     cfg_wr_data,
	// input words
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic signed [SAMPLE_W-1:0] i_sample,
	input  logic signed [SAMPLE_W-1:0] q_sample,
	input  logic                       window_end,
	// result words
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [DB_W-1:0]     power_db,
	output logic        [USED_W-1:0]   samples_used
);

	// widths that follow from the window bound
	localparam int CNT_W = $clog2(MAX_WINDOW + 1);
	localparam int SUM_W = $clog2(MAX_WINDOW) + SQ_W + 1;
	localparam int EXP_W = $clog2(SUM_W);

	typedef enum logic [2:0] {
		IDLE,
		SQ_I,
		SQ_Q,
		ACC_Q,
		LD_SUM,
		NORM_SUM,
		NORM_CNT,
		SCALE_EMIT
	} state_t;

	state_t                     state_q;
	logic                       emit_q;      // scale product is ready, waiting to emit
	logic signed [SAMPLE_W-1:0] i_q;
	logic signed [SAMPLE_W-1:0] q_q;
	logic                       last_q;
	logic        [SUM_W-1:0]    sum_q;
	logic        [CNT_W-1:0]    cnt_q;
	logic signed [PROD_W-1:0]   prod_q;
	logic        [SUM_W-1:0]    norm_x_q;
	logic        [EXP_W-1:0]    norm_e_q;
	logic signed [LOG_W-1:0]    l_sum_q;
	logic signed [LOG_W-1:0]    d_q;
	logic                       zero_q;
	logic signed [DB_W-1:0]     floor_q;
	logic                       out_valid_q;
	logic signed [DB_W-1:0]     power_db_q;
	logic        [USED_W-1:0]   used_q;

	logic signed [MUL_W-1:0]    mul_a;
	logic signed [MUL_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]   mul_p;
	logic                       full;
	logic                       norm_done;
	logic signed [LOG_W-1:0]    log_val;
	logic signed [PROD_W-1:0]   rnd;
	logic signed [LOG_W-1:0]    db_raw;
	logic signed [LOG_W-1:0]    floor_ext;
	logic signed [LOG_W-1:0]    db_sel;
	logic                       out_free;
	logic                       emit_now;

	assign in_stall     = (state_q != IDLE);
	assign out_valid    = out_valid_q;
	assign power_db     = power_db_q;
	assign samples_used = used_q;

	// shared multiplier: squares during accumulation, dB scaling at window end
	always_comb begin
		unique case (state_q)
			SQ_I: begin
				mul_a = MUL_W'(i_q);
				mul_b = MUL_W'(i_q);
			end
			SQ_Q: begin
				mul_a = MUL_W'(q_q);
				mul_b = MUL_W'(q_q);
			end
			SCALE_EMIT: begin
				mul_a = d_q;
				mul_b = DB_SCALE;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end
	assign mul_p = mul_a * mul_b;

	// a full window ignores further samples until it ends
	assign full = (cnt_q == CNT_W'(MAX_WINDOW));

	// shared normalizer: stop on the leading one (or at bit zero)
	assign norm_done = norm_x_q[SUM_W-1] || (norm_e_q == '0);
	assign log_val   = LOG_W'({norm_e_q,
		LOG_FRAC[norm_x_q[SUM_W-2 -: FRAC_IDX_W]]});

	// floor(d * scale / 65536 + 1/2), then clamp to the floor register (also for a zero sum)
	assign rnd       = prod_q + ROUND_HALF;
	assign db_raw    = rnd[PROD_W-1 -: LOG_W];
	assign floor_ext = LOG_W'(floor_q);
	assign db_sel    = (zero_q || (db_raw < floor_ext)) ? floor_ext : db_raw;

	assign out_free  = !out_valid_q || !out_stall;
	// the result register takes a new word once the scale product is ready and the output is free
	assign emit_now  = (state_q == SCALE_EMIT) && emit_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= IDLE;
			emit_q      <= 1'b0;
			i_q         <= '0;
			q_q         <= '0;
			last_q      <= 1'b0;
			sum_q       <= '0;
			cnt_q       <= '0;
			prod_q      <= '0;
			norm_x_q    <= '0;
			norm_e_q    <= '0;
			l_sum_q     <= '0;
			d_q         <= '0;
			zero_q      <= 1'b0;
			floor_q     <= FLOOR_RESET;
			out_valid_q <= 1'b0;
			power_db_q  <= '0;
			used_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				floor_q <= cfg_wr_data;
			end
			// load a new result word, or drop the old one once taken
			if (emit_now) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				IDLE: begin
					if (in_valid) begin
						i_q     <= i_sample;
						q_q     <= q_sample;
						last_q  <= window_end;
						state_q <= SQ_I;
					end
				end
				SQ_I: begin
					prod_q  <= mul_p;
					state_q <= SQ_Q;
				end
				SQ_Q: begin
					if (!full) begin
						sum_q <= sum_q + SUM_W'(prod_q[SQ_W-1:0]);
					end
					prod_q  <= mul_p;
					state_q <= ACC_Q;
				end
				ACC_Q: begin
					if (!full) begin
						sum_q <= sum_q + SUM_W'(prod_q[SQ_W-1:0]);
						cnt_q <= cnt_q + CNT_W'(1);
					end
					state_q <= last_q ? LD_SUM : IDLE;
				end
				LD_SUM: begin
					zero_q   <= (sum_q == '0);
					norm_x_q <= sum_q;
					norm_e_q <= EXP_W'(SUM_W - 1);
					state_q  <= NORM_SUM;
				end
				NORM_SUM: begin
					if (norm_done) begin
						l_sum_q  <= log_val;
						norm_x_q <= SUM_W'(cnt_q);
						norm_e_q <= EXP_W'(SUM_W - 1);
						state_q  <= NORM_CNT;
					end else begin
						norm_x_q <= norm_x_q << 1;
						norm_e_q <= norm_e_q - EXP_W'(1);
					end
				end
				NORM_CNT: begin
					if (norm_done) begin
						d_q     <= l_sum_q - log_val - FS_LOG2_Q8;
						emit_q  <= 1'b0;
						state_q <= SCALE_EMIT;
					end else begin
						norm_x_q <= norm_x_q << 1;
						norm_e_q <= norm_e_q - EXP_W'(1);
					end
				end
				SCALE_EMIT: begin
					if (!emit_q) begin
						// scale the log2 difference
						prod_q <= mul_p;
						emit_q <= 1'b1;
					end else if (out_free) begin
						// load the result word and clear the window
						power_db_q  <= db_sel[DB_W-1:0];
						used_q      <= USED_W'(cnt_q);
						sum_q       <= '0;
						cnt_q       <= '0;
						emit_q      <= 1'b0;
						state_q     <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

`ifndef SYNTH
	// an accepted word keeps the input stalled while it is worked on
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input not stalled after accepting a word");

	// the sample count never passes the window bound
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_WINDOW))
		else $error("sample count beyond window bound");

	// every result covers at least one sample
	a_cnt_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(cnt_q) != '0))
		else $error("result emitted for an empty window");

	// a reported power never lies below the floor in force
	a_floor: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> (power_db_q >= $past(floor_q)))
		else $error("reported power below floor");

	// accumulators clear together with the result
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ((sum_q == '0) && (cnt_q == '0)))
		else $error("accumulators not cleared at window end");
`endif

endmodule
